// File: rtl/cale_pkg.sv
// shared types and constants for the contiguous allocator with lru eviction
// no dependencies
package cale_pkg;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_PLACE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // controller commands to the datapath
  typedef struct packed {
    logic clr_scan;   // restart page pointer and scan registers
    logic step;       // advance page pointer, wrap after last page
    logic do_run;     // run search step on current page
    logic do_old;     // oldest search read on current page
    logic sel_vic;    // address owner table with oldest page
    logic latch_vic;  // take victim owner from read data
    logic do_free;    // free-owner read on current page
    logic do_emit;    // emit step on current page
    logic ld_claim;   // point at run start, clear claim count
    logic do_claim;   // claim step on current page
    logic clr_count;  // restart page pointer and used count
    logic do_count;   // count step on current page
  } cale_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic last_page;  // pointer at last page in service
    logic run_found;
    logic claim_done;
  } cale_sts_t;

endpackage

// File: rtl/cale_ram.sv
// generic single-port ram with registered read
// no dependencies
module cale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, returns old contents on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/cale_datapath.sv
// page table storage and scan datapath
// depends on cale_pkg and cale_ram
module cale_datapath
  import cale_pkg::*;
#(
  parameter int MEM_PAGES = 32,
  parameter int AW = $clog2(MEM_PAGES),
  parameter int CW = $clog2(MEM_PAGES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  cale_cmd_t       cmd,
  input  logic [CW-1:0]   n_pages,
  input  logic [15:0]     req_id,
  input  logic [5:0]      req_need,
  input  logic [31:0]     req_time,
  output cale_sts_t       sts,
  output logic            emit_evict,
  output logic [AW-1:0]   ptr,
  output logic [AW-1:0]   run_start,
  output logic [CW-1:0]   used_cnt
);

  logic [MEM_PAGES-1:0] used;
  logic [MEM_PAGES-1:0] freed;
  logic [15:0]          own_q;
  logic [31:0]          stamp_q;
  logic [CW-1:0]        run_len;
  logic [AW-1:0]        run_s;
  logic                 run_found;
  logic                 any;
  logic [31:0]          best_stamp;
  logic [AW-1:0]        best_idx;
  logic [15:0]          victim;
  logic                 claim_done;
  logic                 claim_we;
  logic                 last_page;
  logic [AW-1:0]        own_addr;
  logic [CW-1:0]        ptr_ext;
  logic [CW:0]          run_inc;
  logic [AW-1:0]        ptr_d;
  logic                 old_v;
  logic                 free_v;

  assign ptr_ext = CW'(ptr);
  assign last_page = (ptr_ext + CW'(1)) >= n_pages;
  assign claim_done = (run_len == CW'(req_need));
  assign claim_we = cmd.do_claim && !claim_done;
  assign run_inc = (CW+1)'(run_len) + (CW+1)'(1);
  assign own_addr = cmd.sel_vic ? best_idx : ptr;

  // owner and stamp tables, addressed by the scan pointer; the owner table takes the oldest page under sel_vic
  cale_ram #(.WIDTH(16), .DEPTH(MEM_PAGES)) u_owner (
    .clk(clk), .we(claim_we), .addr(own_addr),
    .wdata(req_id), .rdata(own_q)
  );
  cale_ram #(.WIDTH(32), .DEPTH(MEM_PAGES)) u_stamp (
    .clk(clk), .we(claim_we), .addr(ptr), .wdata(req_time), .rdata(stamp_q)
  );

  // read data is registered behind the pointer, so table steps use delayed tags
  always_ff @(posedge clk) begin
    if (rst) begin
      old_v <= 1'b0;
      free_v <= 1'b0;
    end else begin
      old_v <= cmd.do_old;
      free_v <= cmd.do_free;
    end
    ptr_d <= ptr;
  end

  // scan pointer and per-pass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      freed <= '0;
      ptr <= '0;
      run_found <= 1'b0;
      any <= 1'b0;
      run_len <= '0;
    end else begin
      // page pointer
      if (cmd.clr_scan || cmd.clr_count) begin
        ptr <= '0;
      end else if (cmd.ld_claim) begin
        ptr <= run_start;
      end else if (claim_we) begin
        ptr <= ptr + AW'(1);
      end else if (cmd.step) begin
        ptr <= last_page ? '0 : ptr + AW'(1);
      end
      if (cmd.clr_scan) begin
        run_len <= '0;
        run_found <= 1'b0;
        any <= 1'b0;
      end else if (cmd.ld_claim) begin
        run_len <= '0;
      end
      // run search: first free run of length req_need
      if (cmd.do_run && !run_found) begin
        if (used[ptr]) begin
          run_len <= '0;
        end else begin
          if (run_len == '0) run_s <= ptr;
          if (run_inc >= (CW+1)'(req_need)) begin
            run_found <= 1'b1;
            if (run_len == '0) run_start <= ptr;
            else run_start <= run_s;
          end
          run_len <= run_inc[CW-1:0];
        end
      end
      // oldest used page, lowest index on tie (uses delayed read data)
      if (old_v && used[ptr_d]) begin
        if (!any || stamp_q < best_stamp) begin
          best_stamp <= stamp_q;
          best_idx <= ptr_d;
        end
        any <= 1'b1;
      end
      if (cmd.latch_vic) begin
        victim <= own_q;
      end
      // free every page of the victim owner
      if (free_v && used[ptr_d] && own_q == victim) begin
        used[ptr_d] <= 1'b0;
        freed[ptr_d] <= 1'b1;
      end
      if (cmd.do_emit) begin
        freed[ptr] <= 1'b0;
      end
      // claim req_need pages from the run start
      if (claim_we) begin
        used[ptr] <= 1'b1;
        run_len <= run_len + CW'(1);
      end
      if (cmd.clr_count) begin
        used_cnt <= '0;
      end else if (cmd.do_count && used[ptr]) begin
        used_cnt <= used_cnt + CW'(1);
      end
    end
  end

  assign emit_evict = cmd.do_emit && freed[ptr];
  assign sts.last_page = last_page;
  assign sts.run_found = run_found;
  assign sts.claim_done = claim_done;

endmodule

// File: rtl/cale_ctrl.sv
// sequencing state machine for the allocator
// depends on cale_pkg
module cale_ctrl
  import cale_pkg::*;
#(
  parameter int MEM_PAGES = 32,
  parameter int CW = $clog2(MEM_PAGES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [5:0]    pages_needed,
  input  logic [CW-1:0] n_pages,
  input  cale_sts_t     sts,
  input  logic          emit_evict,
  output cale_cmd_t     cmd,
  output logic          busy,
  output logic          done_err,
  output logic          done_place
);

  typedef enum logic [3:0] {
    S_IDLE, S_RUN, S_RCHK, S_OLD, S_OLDT, S_VIC, S_VICL, S_FREE, S_FREET,
    S_EMIT, S_CLAIM0, S_CLAIM, S_COUNT0, S_COUNT
  } state_t;

  state_t state;
  logic   too_big;

  assign too_big = 7'(pages_needed) > 7'(n_pages);

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.clr_scan = 1'b1;
      S_RUN: begin
        cmd.do_run = 1'b1;
        cmd.step = 1'b1;
      end
      S_OLD: begin
        cmd.do_old = 1'b1;
        cmd.step = 1'b1;
      end
      S_VIC: cmd.sel_vic = 1'b1;
      S_VICL: cmd.latch_vic = 1'b1;
      S_FREE: begin
        cmd.do_free = 1'b1;
        cmd.step = 1'b1;
      end
      S_FREET: cmd.clr_scan = 1'b1;
      S_EMIT: begin
        cmd.do_emit = 1'b1;
        cmd.step = 1'b1;
      end
      S_CLAIM0: cmd.ld_claim = 1'b1;
      S_CLAIM: cmd.do_claim = 1'b1;
      S_COUNT0: cmd.clr_count = 1'b1;
      S_COUNT: begin
        cmd.do_count = 1'b1;
        cmd.step = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // state and registered strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done_err <= 1'b0;
      done_place <= 1'b0;
    end else begin
      done_err <= (state == S_IDLE) && start && too_big;
      done_place <= (state == S_COUNT) && sts.last_page;
      case (state)
        S_IDLE: if (start && !too_big) state <= S_RUN;
        S_RUN: if (sts.last_page) state <= S_RCHK;
        // run result known after the last page; evict another owner if none
        S_RCHK: state <= sts.run_found ? S_EMIT : S_OLD;
        S_OLD: if (sts.last_page) state <= S_OLDT;
        S_OLDT: state <= S_VIC;
        S_VIC: state <= S_VICL;
        S_VICL: state <= S_FREE;
        S_FREE: if (sts.last_page) state <= S_FREET;
        S_FREET: state <= S_RUN;
        S_EMIT: if (sts.last_page) state <= S_CLAIM0;
        S_CLAIM0: state <= S_CLAIM;
        S_CLAIM: if (sts.claim_done) state <= S_COUNT0;
        S_COUNT0: state <= S_COUNT;
        S_COUNT: if (sts.last_page) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // emit only in emit state
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit_evict |-> state == S_EMIT) else $error("stray evict word");
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    done_err |-> state == S_IDLE) else $error("error word outside idle");
  a_place: assert property (@(posedge clk) disable iff (rst)
    done_place |-> !done_err) else $error("two final words");

endmodule

// File: rtl/contiguous_alloc_lru_evict_core.sv
// Contiguous page allocator with least-recently-used eviction.
// Command channel: drive proc_id, pages_needed and now_time with start high;
// the word is taken at an edge where busy is low. busy stays high while the
// page table is scanned. Results appear on result_kind, page_address,
// used_pages and last for one cycle, marked by result_valid; the receiver
// cannot stall. Evicted pages come first in ascending order, then one
// placement word with last set; an oversized request gives one error word,
// registered as done_err, then as the result; busy stays low. Table passes
// step over the pages in service, one page per cycle. Without eviction busy
// spans run search, evict report, claim and count; each eviction round adds
// an oldest search, an owner read, a free pass and a new run search. The
// placement word is registered from done_place after busy falls. One
// request at a time; the next is taken as soon as busy is low.
// pages_in_service must be written via cfg_we/cfg_data only while idle; the
// block does not enforce this. Reset sets it to MEM_PAGES and marks every
// page free. Depends on cale_pkg, cale_ctrl and cale_datapath.
module contiguous_alloc_lru_evict_core
  import cale_pkg::*;
#(
  parameter int MEM_PAGES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] proc_id,
  input  logic [5:0]  pages_needed,
  input  logic [31:0] now_time,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  output logic        result_valid,
  output logic [1:0]  result_kind,
  output logic [4:0]  page_address,
  output logic [5:0]  used_pages,
  output logic        last
);

  localparam int AW = $clog2(MEM_PAGES);
  localparam int CW = $clog2(MEM_PAGES + 1);

  logic [CW-1:0] n_pages;
  logic [15:0]   req_id;
  logic [5:0]    req_need;
  logic [31:0]   req_time;
  cale_cmd_t     cmd;
  cale_sts_t     sts;
  logic          emit_evict;
  logic          done_err;
  logic          done_place;
  logic [AW-1:0] ptr;
  logic [AW-1:0] run_start;
  logic [CW-1:0] used_cnt;

  // config register with clamping
  always_ff @(posedge clk) begin
    if (rst) begin
      n_pages <= CW'(MEM_PAGES);
    end else if (cfg_we) begin
      if (cfg_data == 6'd0) n_pages <= CW'(1);
      else if (32'(cfg_data) > 32'(MEM_PAGES)) n_pages <= CW'(MEM_PAGES);
      else n_pages <= CW'(cfg_data);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_id <= proc_id;
      req_need <= pages_needed;
      req_time <= now_time;
    end
  end

  cale_ctrl #(.MEM_PAGES(MEM_PAGES)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .pages_needed(pages_needed),
    .n_pages(n_pages), .sts(sts), .emit_evict(emit_evict), .cmd(cmd),
    .busy(busy), .done_err(done_err), .done_place(done_place)
  );

  cale_datapath #(.MEM_PAGES(MEM_PAGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .n_pages(n_pages), .req_id(req_id),
    .req_need(req_need), .req_time(req_time), .sts(sts),
    .emit_evict(emit_evict), .ptr(ptr), .run_start(run_start),
    .used_cnt(used_cnt)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_evict || done_err || done_place;
    end
    if (done_err) begin
      result_kind <= KIND_ERROR;
      page_address <= '0;
      used_pages <= '0;
      last <= 1'b1;
    end else if (done_place) begin
      result_kind <= KIND_PLACE;
      page_address <= 5'(run_start);
      used_pages <= 6'(used_cnt);
      last <= 1'b1;
    end else begin
      result_kind <= KIND_EVICT;
      page_address <= 5'(ptr);
      used_pages <= '0;
      last <= 1'b0;
    end
  end

endmodule
